[rtl/assert_macros.svh]
// assertion helpers for the rtl modules, included by the evaluator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: %m");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition: %m");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

[rtl/pee_pkg.sv]
`default_nettype none
package pee_pkg;

    // stack and datapath sizing
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEP_W  = $clog2(VALUE_WIDTH);
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [STATUS_W-1:0]           status_t;

    // per-cell shift control
    typedef struct packed {
        logic shift_in;   // take the value from the shallower neighbor
        logic shift_out;  // take the value from the deeper neighbor
    } cell_ctrl_t;

    // status codes
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_INVALID  = 2'd1;
    localparam status_t STATUS_DIVZERO  = 2'd2;
    localparam status_t STATUS_OVERFLOW = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage
`default_nettype wire

[rtl/pee_cell.sv]
`default_nettype none
module pee_cell (
    input  wire                 aclk,
    input  pee_pkg::cell_ctrl_t ctrl,
    input  pee_pkg::value_t     shallow_in,
    input  pee_pkg::value_t     deep_in,
    output pee_pkg::value_t     value
);
    import pee_pkg::*;

    value_t value_reg;

    // one stack entry, shifts toward either neighbor
    always_ff @(posedge aclk) begin
        if (ctrl.shift_in) begin
            value_reg <= shallow_in;
        end else if (ctrl.shift_out) begin
            value_reg <= deep_in;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

[rtl/pee_div.sv]
`default_nettype none
module pee_div (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             start,
    input  pee_pkg::value_t dividend,
    input  pee_pkg::value_t divisor,
    output logic            done,
    output pee_pkg::value_t quotient
);
    import pee_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_STEP_W-1:0]   step_reg;
    logic [VALUE_WIDTH-1:0]  rem_reg;
    logic [VALUE_WIDTH-1:0]  quo_reg;
    logic [VALUE_WIDTH-1:0]  dvs_reg;
    logic                    neg_reg;

    logic [VALUE_WIDTH-1:0]  mag_a;
    logic [VALUE_WIDTH-1:0]  mag_b;
    logic [VALUE_WIDTH:0]    shifted;
    logic [VALUE_WIDTH:0]    diff;

    // operand magnitudes
    assign mag_a = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[VALUE_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(VALUE_WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
        end else if (busy_reg) begin
            if (!diff[VALUE_WIDTH]) begin
                rem_reg <= diff[VALUE_WIDTH-1:0];
                quo_reg <= {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[VALUE_WIDTH-1:0];
                quo_reg <= {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    // sign fix, most negative over minus one wraps
    assign quotient = neg_reg ? value_t'(~quo_reg + 1'b1) : value_t'(quo_reg);
    assign done     = done_reg;

endmodule
`default_nettype wire

[rtl/postfix_expression_evaluator_core.sv]
// a digit, + - or * request updates the stack directly; a / request waits in the divide state
//   while the one-bit-per-cycle restoring divider runs, and the stack takes the quotient when done
// a request marked last then moves to the emit state to load the result register, waiting while full
// requests are taken one at a time, and none while a divide or an emit is pending
// reset: aresetn synchronous active low clears count, error and handshake state;
//   stack cells hold no reset and are only read below the count
`default_nettype none
module postfix_expression_evaluator_core (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [pee_pkg::IN_TDATA_W-1:0]        s_tdata,  // [7:0] token_char
    input  wire                                   s_tlast,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [pee_pkg::OUT_TDATA_W-1:0]       m_tdata   // [31:0] result_value,
                                                            // [33:32] status, rest zero
);
    import pee_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    status_t                err_reg, err_next;
    logic                   last_reg, last_next;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                   in_accept;
    logic [7:0]             token;
    logic [3:0]             digit;
    logic                   is_digit;
    logic                   is_op;
    logic                   push;
    logic                   pop;
    logic                   div_start;
    logic                   div_done;
    logic                   out_load;
    value_t                 top_val;
    value_t                 alu_val;
    value_t                 div_quo;
    value_t                 op_a;
    value_t                 op_b;
    status_t                emit_status;
    value_t                 emit_value;
    cell_ctrl_t             ctrl_top;
    cell_ctrl_t             ctrl_rest;
    value_t                 cell_q [STACK_DEPTH];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign token     = s_tdata[7:0];
    assign digit     = 4'(token - CHAR_ZERO);
    assign is_digit  = (token >= CHAR_ZERO) && (token <= CHAR_NINE);
    assign op_b      = cell_q[0];
    assign op_a      = cell_q[1];

    // operator decode
    always_comb begin
        case (token) inside
            CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH: is_op = 1'b1;
            default:                                      is_op = 1'b0;
        endcase
    end

    // combinational alu
    always_comb begin
        case (token)
            CHAR_PLUS:  alu_val = op_a + op_b;
            CHAR_MINUS: alu_val = op_a - op_b;
            CHAR_STAR:  alu_val = op_a * op_b;
            default:    alu_val = '0;
        endcase
    end

    // result seen at the end of an expression
    always_comb begin
        if (err_reg != STATUS_OK) begin
            emit_status = err_reg;
        end else if (count_reg != COUNT_W'(1)) begin
            emit_status = STATUS_INVALID;
        end else begin
            emit_status = STATUS_OK;
        end
        emit_value = (emit_status == STATUS_OK) ? cell_q[0] : '0;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        push       = 1'b0;
        pop        = 1'b0;
        top_val    = alu_val;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    last_next = s_tlast;
                    if (err_reg == STATUS_OK) begin
                        if (is_digit) begin
                            if (count_reg == COUNT_W'(STACK_DEPTH)) begin
                                err_next = STATUS_OVERFLOW;
                            end else begin
                                push       = 1'b1;
                                top_val    = VALUE_WIDTH'(digit);
                                count_next = count_reg + 1'b1;
                            end
                        end else if (!is_op || count_reg < COUNT_W'(2)) begin
                            err_next = STATUS_INVALID;
                        end else if (token == CHAR_SLASH) begin
                            if (op_b == '0) begin
                                err_next = STATUS_DIVZERO;
                            end else begin
                                div_start = 1'b1;
                            end
                        end else begin
                            pop        = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    if (div_start) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pop        = 1'b1;
                    top_val    = div_quo;
                    count_next = count_reg - 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    count_next = '0;
                    err_next   = STATUS_OK;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            err_reg      <= STATUS_OK;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= OUT_TDATA_W'({emit_status, emit_value});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shift controls: top cell loads on push and pop, the rest move as a row
    assign ctrl_top  = '{shift_in: push || pop, shift_out: 1'b0};
    assign ctrl_rest = '{shift_in: push, shift_out: pop};

    // operand stack as a row of cells, top entry in cell zero
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_top
            pee_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl_top),
                .shallow_in (top_val),
                .deep_in    (cell_q[1]),
                .value      (cell_q[0])
            );
        end else if (i == STACK_DEPTH - 1) begin : g_bottom
            pee_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl_rest),
                .shallow_in (cell_q[i-1]),
                .deep_in    ('0),
                .value      (cell_q[i])
            );
        end else begin : g_mid
            pee_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl_rest),
                .shallow_in (cell_q[i-1]),
                .deep_in    (cell_q[i+1]),
                .value      (cell_q[i])
            );
        end
    end

    // iterative divider
    pee_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (op_a),
        .divisor  (op_b),
        .done     (div_done),
        .quotient (div_quo)
    );

    // checks
    `ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > COUNT_W'(STACK_DEPTH))
    `ASSERT_PROP(a_div_done_in_div, aclk, aresetn, div_done |-> state_reg == ST_DIV)
    `ASSERT_PROP(a_emit_clears, aclk, aresetn, out_load |=> count_reg == '0 && err_reg == STATUS_OK)

endmodule
`default_nettype wire
